>>> src/hsha_pkg.sv
// Shared types and constants for the HMAC-SHA-1 engine.
package hsha_pkg;

	localparam logic [1:0] MODE_KEY = 2'd0;
	localparam logic [1:0] MODE_MSG = 2'd1;
	localparam logic [1:0] MODE_FIN = 2'd2;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
		32'h10325476, 32'hC3D2E1F0};

	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5c;
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_FILL = 6'd56;  // 448 bits

	typedef enum logic [2:0] {
		SRC_IN,
		SRC_KEY,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN,
		SRC_DIG
	} src_t;

	typedef struct packed {
		logic       init;
		logic       absorb;
		src_t       src;
		logic [6:0] idx;
		logic       cstart;
		logic       round;
		logic       cend;
		logic       latch_in;
		logic       latch_dig;
		logic       key_wr;
		logic       key_new;
		logic [5:0] key_addr;
		logic       outer;
		logic [2:0] out_idx;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
	} stat_t;

endpackage

>>> src/hsha_in_if.sv
// Input channel: mode and data byte.
interface hsha_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] data_byte;
	modport source (output valid, mode, data_byte, input ready);
	modport sink (input valid, mode, data_byte, output ready);
endinterface

>>> src/hsha_out_if.sv
// Output channel: digest words.
interface hsha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> src/hsha_dp.sv
// Datapath: key store, block window, SHA-1 round unit and chaining values.
module hsha_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  hsha_pkg::cmd_t      cmd,
	input  logic [7:0]          data_byte,
	output hsha_pkg::stat_t     stat,
	output logic [31:0]         digest_word
);
	logic [7:0]   key_mem [64];
	logic [6:0]   key_fill_q;
	logic [7:0]   key_rd_q;
	logic         key_ok_q;
	logic [7:0]   hold_q;
	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [63:0]  len_q;
	logic [159:0] chain_q;
	logic [159:0] dig_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [7:0]   byte_mux;
	logic [63:0]  len_sh;
	logic [159:0] dig_sh;
	logic [31:0]  f, k, w_new, tmp;

	assign stat.fill = fill_q;

	always_ff @(posedge clk) begin
		if (cmd.key_wr) begin
			if (cmd.key_new) begin
				key_mem[0] <= data_byte;
			end else if (!key_fill_q[6]) begin
				key_mem[key_fill_q[5:0]] <= data_byte;
			end
		end
		key_rd_q <= key_mem[cmd.key_addr];
		key_ok_q <= {1'b0, cmd.key_addr} < key_fill_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_fill_q <= '0;
		end else if (cmd.key_wr) begin
			if (cmd.key_new) key_fill_q <= 7'd1;
			else if (!key_fill_q[6]) key_fill_q <= key_fill_q + 7'd1;
		end
	end

	assign len_sh = len_q << {cmd.idx[2:0], 3'b000};
	assign dig_sh = dig_q << {cmd.idx[4:0], 3'b000};

	always_comb begin
		case (cmd.src)
			hsha_pkg::SRC_IN:   byte_mux = hold_q;
			hsha_pkg::SRC_KEY:  byte_mux = (key_ok_q ? key_rd_q : 8'h00) ^
				(cmd.outer ? hsha_pkg::OPAD : hsha_pkg::IPAD);
			hsha_pkg::SRC_MARK: byte_mux = hsha_pkg::PAD_MARK;
			hsha_pkg::SRC_LEN:  byte_mux = len_sh[63:56];
			hsha_pkg::SRC_DIG:  byte_mux = dig_sh[159:152];
			default:            byte_mux = 8'h00;
		endcase
	end

	always_comb begin
		if (cmd.idx < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = hsha_pkg::K0;
		end else if (cmd.idx < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = hsha_pkg::K1;
		end else if (cmd.idx < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = hsha_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = hsha_pkg::K3;
		end
	end

	// window word 0 is W[t]; the appended word is W[t+16]
	assign w_new = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
	assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + blk_q[511:480];

	always_ff @(posedge clk) begin
		if (cmd.latch_in) hold_q <= data_byte;
		if (cmd.latch_dig) dig_q <= chain_q;
		if (cmd.absorb) begin
			blk_q <= {blk_q[503:0], byte_mux};
			if (cmd.src == hsha_pkg::SRC_MARK) len_q <= bits_q;
		end else if (cmd.round) begin
			blk_q <= {blk_q[479:0], w_new[30:0], w_new[31]};
		end
		if (cmd.cstart) begin
			{a_q, b_q, c_q, d_q, e_q} <= chain_q;
		end else if (cmd.round) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= hsha_pkg::SHA1_IV;
			fill_q  <= '0;
			bits_q  <= '0;
		end else if (cmd.init) begin
			chain_q <= hsha_pkg::SHA1_IV;
			fill_q  <= '0;
			bits_q  <= '0;
		end else begin
			if (cmd.absorb) begin
				fill_q <= fill_q + 6'd1;
				bits_q <= bits_q + 64'd8;
			end
			if (cmd.cend) begin
				chain_q <= {chain_q[159:128] + a_q, chain_q[127:96] + b_q,
					chain_q[95:64] + c_q, chain_q[63:32] + d_q, chain_q[31:0] + e_q};
			end
		end
	end

	always_comb begin
		case (cmd.out_idx)
			3'd0:    digest_word = chain_q[159:128];
			3'd1:    digest_word = chain_q[127:96];
			3'd2:    digest_word = chain_q[95:64];
			3'd3:    digest_word = chain_q[63:32];
			default: digest_word = chain_q[31:0];
		endcase
	end

endmodule

>>> src/hsha_ctrl.sv
// Controller: sequences key load, absorb, padding, compression and output.
module hsha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_mode,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output hsha_pkg::cmd_t      cmd,
	input  hsha_pkg::stat_t     stat
);
	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_KEY    = 11'b00000000010,
		S_MSG    = 11'b00000000100,
		S_PADM   = 11'b00000001000,
		S_PADZ   = 11'b00000010000,
		S_LEN    = 11'b00000100000,
		S_DIG    = 11'b00001000000,
		S_CSTART = 11'b00010000000,
		S_ROUND  = 11'b00100000000,
		S_CEND   = 11'b01000000000,
		S_OINIT  = 11'b10000000000
	} state_t;

	state_t     st_q, ret_q, after;
	logic       out_q;
	logic [6:0] cnt_q;
	logic       open_q, prev_key_q, outer_q, fin_q;
	logic       acc;
	logic       full;
	logic [5:0] fill_nx;

	assign acc = in_valid && in_ready;
	assign full = stat.fill == 6'd63;
	assign fill_nx = stat.fill + 6'd1;
	assign out_valid = out_q;

	always_comb begin
		cmd = '0;
		cmd.outer = outer_q;
		cmd.idx = cnt_q;
		cmd.key_addr = cnt_q[5:0];
		cmd.out_idx = cnt_q[2:0];
		in_ready = 1'b0;
		after = S_IDLE;
		unique case (st_q)
			S_IDLE: begin
				in_ready = !out_q;
				if (acc) begin
					if (in_mode == hsha_pkg::MODE_KEY) begin
						cmd.key_wr = 1'b1;
						cmd.key_new = !prev_key_q;
					end else if (in_mode == hsha_pkg::MODE_MSG ||
						in_mode == hsha_pkg::MODE_FIN) begin
						cmd.latch_in = 1'b1;
						cmd.init = !open_q;
					end
				end
			end
			S_KEY: begin
				cmd.absorb = cnt_q != 7'd0;
				cmd.src = hsha_pkg::SRC_KEY;
				after = outer_q ? S_DIG : (fin_q ? S_PADM : S_MSG);
			end
			S_MSG: begin
				cmd.absorb = 1'b1;
				cmd.src = hsha_pkg::SRC_IN;
				after = S_IDLE;
			end
			S_PADM: begin
				cmd.absorb = 1'b1;
				cmd.src = hsha_pkg::SRC_MARK;
				after = (fill_nx == hsha_pkg::LEN_FILL) ? S_LEN : S_PADZ;
			end
			S_PADZ: begin
				cmd.absorb = 1'b1;
				cmd.src = hsha_pkg::SRC_ZERO;
				after = (fill_nx == hsha_pkg::LEN_FILL) ? S_LEN : S_PADZ;
			end
			S_LEN: begin
				cmd.absorb = 1'b1;
				cmd.src = hsha_pkg::SRC_LEN;
				after = (cnt_q == 7'd7) ? (outer_q ? S_IDLE : S_OINIT) : S_LEN;
			end
			S_DIG: begin
				cmd.absorb = 1'b1;
				cmd.src = hsha_pkg::SRC_DIG;
				after = (cnt_q == 7'd19) ? S_PADM : S_DIG;
			end
			S_CSTART: cmd.cstart = 1'b1;
			S_ROUND:  cmd.round = 1'b1;
			S_CEND:   cmd.cend = 1'b1;
			S_OINIT: begin
				cmd.latch_dig = 1'b1;
				cmd.init = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			ret_q      <= S_IDLE;
			out_q      <= 1'b0;
			cnt_q      <= '0;
			open_q     <= 1'b0;
			prev_key_q <= 1'b0;
			outer_q    <= 1'b0;
			fin_q      <= 1'b0;
		end else begin
			unique case (st_q) inside
				S_IDLE: begin
					if (out_q) begin
						if (out_ready) begin
							if (cnt_q == 7'd4) begin
								out_q  <= 1'b0;
								open_q <= 1'b0;
								cnt_q  <= '0;
							end else begin
								cnt_q <= cnt_q + 7'd1;
							end
						end
					end else if (acc) begin
						if (in_mode == hsha_pkg::MODE_KEY) begin
							prev_key_q <= 1'b1;
							open_q     <= 1'b0;
						end else if (in_mode == hsha_pkg::MODE_MSG ||
							in_mode == hsha_pkg::MODE_FIN) begin
							prev_key_q <= 1'b0;
							fin_q      <= in_mode == hsha_pkg::MODE_FIN;
							cnt_q      <= '0;
							if (!open_q) begin
								open_q  <= 1'b1;
								outer_q <= 1'b0;
								st_q    <= S_KEY;
							end else begin
								st_q <= (in_mode == hsha_pkg::MODE_FIN) ? S_PADM : S_MSG;
							end
						end
					end
				end
				S_KEY: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd64) begin
						ret_q <= after;
						st_q  <= S_CSTART;
					end
				end
				S_MSG, S_PADM, S_PADZ, S_LEN, S_DIG: begin
					if (st_q == S_LEN || st_q == S_DIG) begin
						cnt_q <= (after == st_q) ? cnt_q + 7'd1 : 7'd0;
					end else begin
						cnt_q <= '0;
					end
					if (full) begin
						ret_q <= after;
						st_q  <= S_CSTART;
					end else begin
						st_q <= after;
					end
				end
				S_CSTART: begin
					cnt_q <= '0;
					st_q  <= S_ROUND;
				end
				S_ROUND: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd79) st_q <= S_CEND;
				end
				S_CEND: begin
					cnt_q <= '0;
					st_q  <= ret_q;
					// the outer length block ends the job: start emitting
					if (ret_q == S_IDLE && outer_q) out_q <= 1'b1;
				end
				S_OINIT: begin
					outer_q <= 1'b1;
					cnt_q   <= '0;
					st_q    <= S_KEY;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> src/hmac_sha1_engine.sv
// HMAC-SHA-1 engine top level: controller plus datapath.
// Key beats are stored while idle. A message beat is latched, then absorbed, with a
// compression when it completes a block. Opening a message adds keyed-pad absorb and
// a compression. Finish: padding, outer hash and up to four compressions, then five
// output beats. Rate is set by the single SHA-1 round unit, one round per cycle.
// arst_n clears key length, message state and the chaining values.
module hmac_sha1_engine (
	input logic         clk,
	input logic         arst_n,
	hsha_in_if.sink     req,
	hsha_out_if.source  rsp
);
	hsha_pkg::cmd_t  cmd;
	hsha_pkg::stat_t stat;

	hsha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_mode   (req.mode),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	hsha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (req.data_byte),
		.stat        (stat),
		.digest_word (rsp.digest_word)
	);

	assign rsp.word_index = cmd.out_idx;
	assign rsp.last_word  = cmd.out_idx == 3'd4;

endmodule

>>> src/hsha_chk.sv
// Port-level checks for the HMAC-SHA-1 engine, bound to the top level.
module hsha_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd4)))
		else $error("last_word out of step with word_index");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=>
		(out_valid && word_index == $past(word_index) + 3'd1))
		else $error("digest beats not consecutive");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> !out_valid)
		else $error("beat after last word");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while digest pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(digest_word)))
		else $error("stalled beat changed");
endmodule

bind hmac_sha1_engine hsha_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.digest_word (rsp.digest_word),
	.word_index  (rsp.word_index),
	.last_word   (rsp.last_word)
);

>>> verif/tb_hmac_sha1_engine.sv
// Self-checking testbench for the HMAC-SHA-1 engine.
module tb_hmac_sha1_engine;

	// mode code that the engine ignores
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	bit failed = 1'b0;

	hsha_in_if req();
	hsha_out_if rsp();

	hmac_sha1_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	typedef struct {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} hmac_word_t;

	typedef struct {
		logic [1:0]  mode;
		logic [7:0]  data_byte;
		logic        has_digest;
		logic [31:0] digest0;
	} stim_row_t;

	// predictor state
	logic [31:0] pr_chain[5];
	logic [7:0]  pr_block[64];
	int          pr_fill;
	logic [63:0] pr_bits;
	logic [7:0]  pr_key[64];
	int          pr_key_len;
	bit          pr_msg_open;
	bit          pr_prev_key;

	hmac_word_t digest_q[$];
	logic [31:0] typed_q[$];
	bit          typed_valid_q[$];

	function automatic logic [31:0] rol(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic sha_compress();
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {pr_block[4*i], pr_block[4*i+1], pr_block[4*i+2], pr_block[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = pr_chain[0]; b = pr_chain[1]; c = pr_chain[2]; d = pr_chain[3]; e = pr_chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = hsha_pkg::K0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = hsha_pkg::K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = hsha_pkg::K2;
			end else begin
				f = b ^ c ^ d; k = hsha_pkg::K3;
			end
			t = rol(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		pr_chain[0] += a; pr_chain[1] += b; pr_chain[2] += c;
		pr_chain[3] += d; pr_chain[4] += e;
	endtask

	task automatic sha_absorb(logic [7:0] v);
		pr_block[pr_fill] = v;
		pr_fill++;
		pr_bits += 64'd8;
		if (pr_fill == 64) begin
			sha_compress();
			pr_fill = 0;
		end
	endtask

	task automatic sha_start(logic [7:0] pad);
		for (int i = 0; i < 5; i++)
			pr_chain[i] = hsha_pkg::SHA1_IV[159 - 32*i -: 32];
		pr_fill = 0;
		pr_bits = '0;
		for (int i = 0; i < 64; i++)
			sha_absorb(pr_key[i] ^ pad);
	endtask

	task automatic sha_pad();
		logic [63:0] len;
		len = pr_bits;
		sha_absorb(hsha_pkg::PAD_MARK);
		while (pr_fill != hsha_pkg::LEN_FILL)
			sha_absorb(8'h00);
		for (int i = 0; i < 8; i++)
			sha_absorb(len[63 - 8*i -: 8]);
	endtask

	task automatic hmac_reset();
		for (int i = 0; i < 5; i++)
			pr_chain[i] = hsha_pkg::SHA1_IV[159 - 32*i -: 32];
		for (int i = 0; i < 64; i++)
			pr_key[i] = '0;
		pr_fill = 0;
		pr_bits = '0;
		pr_key_len = 0;
		pr_msg_open = 0;
		pr_prev_key = 0;
	endtask

	// Updates the model for one accepted beat and queues any digest words.
	task automatic hmac_predict(logic [1:0] mode, logic [7:0] data);
		logic [7:0] inner[20];
		hmac_word_t wd;
		if (mode == hsha_pkg::MODE_KEY) begin
			if (!pr_prev_key) begin
				for (int i = 0; i < 64; i++)
					pr_key[i] = '0;
				pr_key_len = 0;
			end
			if (pr_key_len < 64) begin
				pr_key[pr_key_len] = data;
				pr_key_len++;
			end
			pr_prev_key = 1;
			pr_msg_open = 0;
			return;
		end
		if (mode != hsha_pkg::MODE_MSG && mode != hsha_pkg::MODE_FIN)
			return;
		pr_prev_key = 0;
		if (!pr_msg_open) begin
			sha_start(hsha_pkg::IPAD);
			pr_msg_open = 1;
		end
		if (mode == hsha_pkg::MODE_MSG) begin
			sha_absorb(data);
			return;
		end
		sha_pad();
		for (int i = 0; i < 20; i++)
			inner[i] = pr_chain[i/4][31 - 8*(i%4) -: 8];
		sha_start(hsha_pkg::OPAD);
		for (int i = 0; i < 20; i++)
			sha_absorb(inner[i]);
		sha_pad();
		pr_msg_open = 0;
		for (int i = 0; i < 5; i++) begin
			wd.digest_word = pr_chain[i];
			wd.word_index = 3'(i);
			wd.last_word = (i == 4);
			digest_q.push_back(wd);
		end
	endtask

	// Directed rows; digest typed in only for the empty-key, empty-message case
	// (HMAC-SHA1("", "") = fbdb1d1b...).
	stim_row_t rows[] = '{
		'{hsha_pkg::MODE_FIN, 8'h00, 1'b1, 32'hfbdb1d1b},
		'{MODE_SPARE, 8'hff, 1'b0, 32'h0},
		'{hsha_pkg::MODE_KEY, 8'hff, 1'b0, 32'h0},
		'{hsha_pkg::MODE_KEY, 8'h00, 1'b0, 32'h0},
		'{hsha_pkg::MODE_MSG, 8'h00, 1'b0, 32'h0},
		'{hsha_pkg::MODE_MSG, 8'hff, 1'b0, 32'h0},
		'{hsha_pkg::MODE_MSG, 8'ha5, 1'b0, 32'h0},
		'{hsha_pkg::MODE_FIN, 8'hff, 1'b0, 32'h0},
		'{hsha_pkg::MODE_MSG, 8'h5a, 1'b0, 32'h0},
		'{hsha_pkg::MODE_FIN, 8'h00, 1'b0, 32'h0},
		'{hsha_pkg::MODE_KEY, 8'h11, 1'b0, 32'h0},
		'{hsha_pkg::MODE_MSG, 8'h22, 1'b0, 32'h0},
		'{hsha_pkg::MODE_KEY, 8'h33, 1'b0, 32'h0},
		'{MODE_SPARE, 8'h00, 1'b0, 32'h0},
		'{hsha_pkg::MODE_MSG, 8'h44, 1'b0, 32'h0},
		'{hsha_pkg::MODE_FIN, 8'h00, 1'b0, 32'h0},
		'{hsha_pkg::MODE_FIN, 8'h00, 1'b0, 32'h0}
	};

	int gap_left;
	logic out_stall;

	// Drive one beat, inserting random gaps between bursts.
	task automatic send_beat(logic [1:0] mode, logic [7:0] data);
		if (gap_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			gap_left = $urandom_range(1, 30);
		end
		gap_left--;
		req.valid <= 1'b1;
		req.mode <= mode;
		req.data_byte <= data;
		do @(posedge clk); while (!req.ready);
		hmac_predict(mode, data);
	endtask

	// Receiver stalls in a slowly varying pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 3))
				0: out_stall <= ($urandom_range(0, 3) == 0);
				1: out_stall <= 1'b0;
				default: out_stall <= out_stall;
			endcase
		end
	end
	assign rsp.ready = arst_n && !out_stall;

	always @(posedge clk) begin
		hmac_word_t exp_w;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (digest_q.size() == 0) begin
				$error("unexpected digest word %h", rsp.digest_word);
				failed = 1;
			end else begin
				exp_w = digest_q.pop_front();
				if (rsp.word_index == 3'd0 && typed_q.size() != 0) begin
					if (typed_valid_q.pop_front() && typed_q[0] !== rsp.digest_word) begin
						$error("digest_word (typed) exp %h got %h", typed_q[0],
							rsp.digest_word);
						failed = 1;
					end
					void'(typed_q.pop_front());
				end
				if (rsp.digest_word !== exp_w.digest_word) begin
					$error("digest_word exp %h got %h", exp_w.digest_word, rsp.digest_word);
					failed = 1;
				end
				if (rsp.word_index !== exp_w.word_index) begin
					$error("word_index exp %0d got %0d", exp_w.word_index, rsp.word_index);
					failed = 1;
				end
				if (rsp.last_word !== exp_w.last_word) begin
					$error("last_word exp %b got %b", exp_w.last_word, rsp.last_word);
					failed = 1;
				end
			end
		end
	end

	initial begin
		int klen, mlen;
		gap_left = 0;
		hmac_reset();
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.mode = hsha_pkg::MODE_KEY;
		req.data_byte = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].mode == hsha_pkg::MODE_FIN) begin
				typed_q.push_back(rows[i].digest0);
				typed_valid_q.push_back(rows[i].has_digest);
			end
			send_beat(rows[i].mode, rows[i].data_byte);
		end
		// long key: bytes past 64 dropped
		for (int i = 0; i < 70; i++)
			send_beat(hsha_pkg::MODE_KEY, 8'($urandom));
		send_beat(hsha_pkg::MODE_MSG, 8'h01);
		send_beat(hsha_pkg::MODE_FIN, 8'h00);
		// random sequences of key, message, finish with occasional noise
		for (int n = 0; n < 360; ) begin
			if ($urandom_range(0, 2) != 0) begin
				klen = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 68)
					: $urandom_range(1, 20);
				for (int i = 0; i < klen; i++) begin
					send_beat(hsha_pkg::MODE_KEY, 8'($urandom));
					n++;
				end
			end
			mlen = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130)
				: $urandom_range(0, 20);
			for (int i = 0; i < mlen; i++) begin
				case ($urandom_range(0, 29))
					0: send_beat(MODE_SPARE, 8'($urandom));
					1: send_beat(hsha_pkg::MODE_KEY, 8'($urandom));
					default: send_beat(hsha_pkg::MODE_MSG, 8'($urandom));
				endcase
				n++;
			end
			send_beat(hsha_pkg::MODE_FIN, 8'($urandom));
			n++;
		end
		req.valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (!failed)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
